// File: rtl/core/token_boundary_detector_unit_assert.svh
// assertion helpers for the token boundary detector
`ifndef TOKEN_BOUNDARY_DETECTOR_UNIT_ASSERT_SVH
`define TOKEN_BOUNDARY_DETECTOR_UNIT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define TBD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define TBD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/tbd_pkg.sv
`default_nettype none

package tbd_pkg;

    // special characters
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_EQUALS    = 8'h3D;

    // token kinds
    localparam logic [1:0] KIND_IDENT  = 2'd0;
    localparam logic [1:0] KIND_INT    = 2'd1;
    localparam logic [1:0] KIND_STRING = 2'd2;
    localparam logic [1:0] KIND_OTHER  = 2'd3;

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_input;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  token_kind;
        logic [31:0] token_start;
        logic [15:0] token_length;
        logic        length_saturated;
        logic        unterminated;
    } t_out_item;

    // pending-token context handed to the decision logic
    typedef struct packed {
        logic [7:0] prev_char;
        logic       pending;
        logic       len_ge2;
        logic       starts_quote;
        logic       bs_before_last_odd;
        logic       seen_letter;
        logic       seen_digit;
    } t_ctx;

    // boundary decision for one character
    typedef struct packed {
        logic       emit;
        logic       clear;
        logic [1:0] kind;
        logic       unterm;
        logic       seen_letter;
        logic       seen_digit;
    } t_decision;

endpackage

`default_nettype wire

// File: rtl/core/tbd_step.sv
`default_nettype none

module tbd_step
    import tbd_pkg::*;
(
    input  wire t_in_item  i_item,
    input  wire t_ctx      i_ctx,
    output t_decision      o_dec
);

    function automatic logic is_space(input logic [7:0] c);
        return ((c >= 8'd9) && (c <= 8'd13)) || (c == 8'd32);
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= 8'd65) && (c <= 8'd90)) || ((c >= 8'd97) && (c <= 8'd122));
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'd48) && (c <= 8'd57);
    endfunction

    function automatic logic is_punct(input logic [7:0] c);
        return (c >= 8'd33) && (c <= 8'd126) && !is_letter(c) && !is_digit(c);
    endfunction

    logic       w_last_letter;
    logic       w_last_digit;
    logic       w_seen_letter;
    logic       w_seen_digit;
    logic       w_closed;
    logic [1:0] w_flag_kind;
    logic [7:0] w_c;
    logic [7:0] w_p;

    assign w_c = i_item.char_code;
    assign w_p = i_ctx.prev_char;

    // last buffered character is only marked once it is known to stay
    assign w_last_letter = is_letter(w_p);
    assign w_last_digit  = is_digit(w_p);
    assign w_seen_letter = i_ctx.seen_letter | (i_ctx.pending & w_last_letter);
    assign w_seen_digit  = i_ctx.seen_digit | (i_ctx.pending & w_last_digit);

    // closing quote, not escaped, and not the opening quote on its own
    assign w_closed = i_ctx.len_ge2 && (w_p == CH_QUOTE) && !i_ctx.bs_before_last_odd;

    always_comb begin
        if (w_seen_letter) begin
            w_flag_kind = KIND_IDENT;
        end else if (w_seen_digit) begin
            w_flag_kind = KIND_INT;
        end else begin
            w_flag_kind = KIND_OTHER;
        end
    end

    always_comb begin
        o_dec.emit        = 1'b0;
        o_dec.clear       = 1'b0;
        o_dec.kind        = i_ctx.starts_quote ? KIND_STRING : w_flag_kind;
        o_dec.unterm      = 1'b0;
        o_dec.seen_letter = w_seen_letter;
        o_dec.seen_digit  = w_seen_digit;
        if (i_ctx.pending) begin
            if (i_item.end_of_input) begin
                o_dec.clear  = 1'b1;
                o_dec.emit   = i_ctx.starts_quote || !is_space(w_p);
                o_dec.unterm = i_ctx.starts_quote && !w_closed;
            end else if (i_ctx.starts_quote) begin
                o_dec.emit  = w_closed;
                o_dec.clear = w_closed;
            end else if (is_space(w_p)) begin
                o_dec.clear = 1'b1;
            end else if (is_space(w_c)) begin
                o_dec.emit  = 1'b1;
                o_dec.clear = 1'b1;
            end else if (is_punct(w_c)) begin
                // '=' after punctuation extends the operator
                if (!(is_punct(w_p) && (w_c == CH_EQUALS))) begin
                    o_dec.emit  = 1'b1;
                    o_dec.clear = 1'b1;
                end
            end else if ((is_letter(w_c) || is_digit(w_c)) && is_punct(w_p)) begin
                o_dec.emit  = 1'b1;
                o_dec.clear = 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/token_boundary_detector_unit.sv
`default_nettype none

// channel   direction  payload      handshake
// -------   ---------  -----------  -------------------------------
// in        input      t_in_item    i_in_valid / o_in_ready
// out       output     t_out_item   o_out_valid / i_out_ready
//
// one character per cycle while o_in_ready is high: each transfer is classified and the
// pending token updated in the same cycle, the result lands in the output register, or in
// the skid entry while the output is held; at most one result per transfer
// a two-entry output buffer (output register plus skid) keeps o_in_ready
// registered, it drops only while both entries are held by a stalled sink
// synchronous active-low reset empties the token buffer and the output

module token_boundary_detector_unit
    import tbd_pkg::*;
#(
    parameter int LENGTH_BITS = 16,
    parameter int OFFSET_BITS = 32
) (
    input  wire       i_clk,
    input  wire       i_rst_n,
    input  wire       i_in_valid,
    output logic      o_in_ready,
    input  wire t_in_item  i_in_data,
    output logic      o_out_valid,
    input  wire       i_out_ready,
    output t_out_item o_out_data
);

    // pending token state
    logic [LENGTH_BITS-1:0] r_len,    n_len;
    logic [OFFSET_BITS-1:0] r_start,  n_start;
    logic [OFFSET_BITS-1:0] r_offset, n_offset;
    logic [7:0]             r_prev,   n_prev;
    logic                   r_swq,    n_swq;
    logic                   r_bs_odd, n_bs_odd;
    logic                   r_bbl_odd, n_bbl_odd;
    logic                   r_seen_letter, n_seen_letter;
    logic                   r_seen_digit,  n_seen_digit;
    logic                   r_ovf,    n_ovf;

    // output buffer
    t_out_item r_out;
    t_out_item r_skid;
    logic      r_out_valid;
    logic      r_skid_valid;

    logic                   w_fire;
    logic                   w_take;
    t_ctx                   w_ctx;
    t_decision              w_dec;
    t_out_item              w_res;
    logic [LENGTH_BITS-1:0] w_len_after;
    logic                   w_ovf_after;
    logic                   w_run_after;
    logic [LENGTH_BITS+15:0] w_len_ext;
    logic [OFFSET_BITS+31:0] w_start_ext;

    assign o_in_ready  = !r_skid_valid;
    assign w_fire      = i_in_valid && o_in_ready;
    assign w_take      = r_out_valid && i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign w_ctx.prev_char          = r_prev;
    assign w_ctx.pending            = |r_len;
    assign w_ctx.len_ge2            = |r_len[LENGTH_BITS-1:1];
    assign w_ctx.starts_quote       = r_swq;
    assign w_ctx.bs_before_last_odd = r_bbl_odd;
    assign w_ctx.seen_letter        = r_seen_letter;
    assign w_ctx.seen_digit         = r_seen_digit;

    tbd_step u_step (
        .i_item (i_in_data),
        .i_ctx  (w_ctx),
        .o_dec  (w_dec)
    );

    // result fields are reported modulo their port widths
    assign w_len_ext   = {16'd0, r_len};
    assign w_start_ext = {32'd0, r_start};

    always_comb begin
        w_res.token_kind       = w_dec.kind;
        w_res.token_start      = w_start_ext[31:0];
        w_res.token_length     = w_len_ext[15:0];
        w_res.length_saturated = r_ovf;
        w_res.unterminated     = w_dec.unterm;
    end

    // state after the boundary decision, before the new character is buffered
    assign w_len_after = w_dec.clear ? '0 : r_len;
    assign w_ovf_after = w_dec.clear ? 1'b0 : r_ovf;
    assign w_run_after = w_dec.clear ? 1'b0 : r_bs_odd;

    always_comb begin
        n_len         = r_len;
        n_start       = r_start;
        n_offset      = r_offset;
        n_prev        = r_prev;
        n_swq         = r_swq;
        n_bs_odd      = r_bs_odd;
        n_bbl_odd     = r_bbl_odd;
        n_seen_letter = r_seen_letter;
        n_seen_digit  = r_seen_digit;
        n_ovf         = r_ovf;
        if (w_fire) begin
            if (i_in_data.end_of_input) begin
                // flush: end mark is not a character, offset does not move
                if (w_dec.clear) begin
                    n_len         = '0;
                    n_swq         = 1'b0;
                    n_bs_odd      = 1'b0;
                    n_bbl_odd     = 1'b0;
                    n_seen_letter = 1'b0;
                    n_seen_digit  = 1'b0;
                    n_ovf         = 1'b0;
                end
            end else begin
                n_seen_letter = w_dec.clear ? 1'b0 : w_dec.seen_letter;
                n_seen_digit  = w_dec.clear ? 1'b0 : w_dec.seen_digit;
                n_swq         = w_dec.clear ? 1'b0 : r_swq;
                if (w_len_after == '0) begin
                    n_start = r_offset;
                    n_swq   = (i_in_data.char_code == CH_QUOTE);
                end
                // length sticks at all ones once the counter is full
                if (&w_len_after) begin
                    n_len = w_len_after;
                    n_ovf = 1'b1;
                end else begin
                    n_len = w_len_after + 1'b1;
                    n_ovf = w_ovf_after;
                end
                n_bbl_odd = w_run_after;
                n_bs_odd  = (i_in_data.char_code == CH_BACKSLASH) ? !w_run_after : 1'b0;
                n_prev    = i_in_data.char_code;
                n_offset  = r_offset + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len         <= '0;
            r_start       <= '0;
            r_offset      <= '0;
            r_prev        <= '0;
            r_swq         <= 1'b0;
            r_bs_odd      <= 1'b0;
            r_bbl_odd     <= 1'b0;
            r_seen_letter <= 1'b0;
            r_seen_digit  <= 1'b0;
            r_ovf         <= 1'b0;
        end else begin
            r_len         <= n_len;
            r_start       <= n_start;
            r_offset      <= n_offset;
            r_prev        <= n_prev;
            r_swq         <= n_swq;
            r_bs_odd      <= n_bs_odd;
            r_bbl_odd     <= n_bbl_odd;
            r_seen_letter <= n_seen_letter;
            r_seen_digit  <= n_seen_digit;
            r_ovf         <= n_ovf;
        end
    end

    // output register with skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            // no new transfer can arrive while the skid entry is full
            if (w_take) begin
                r_skid_valid <= 1'b0;
            end
        end else if (w_fire && w_dec.emit) begin
            if (!r_out_valid || w_take) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (w_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (w_take) begin
                r_out <= r_skid;
            end
        end else if (w_fire && w_dec.emit) begin
            if (!r_out_valid || w_take) begin
                r_out <= w_res;
            end else begin
                r_skid <= w_res;
            end
        end
    end

`include "token_boundary_detector_unit_assert.svh"

    // skid entry only ever fills behind a held output
    `TBD_ASSERT_IMP(a_skid_behind_out, r_skid_valid, r_out_valid, "skid full with empty output")
    // a token is only reported from a non-empty buffer
    `TBD_ASSERT_IMP(a_emit_nonempty, w_fire && w_dec.emit, r_len != '0, "emit from empty buffer")
    // the open-string flag belongs to string tokens only
    `TBD_ASSERT_IMP(a_unterm_string, w_dec.unterm, w_dec.kind == KIND_STRING,
                    "unterminated flag on non-string token")
    // an end mark always leaves the buffer empty
    `TBD_ASSERT_NEXT(a_eoi_flush, w_fire && i_in_data.end_of_input, r_len == '0,
                     "buffer not empty after end mark")

endmodule

`default_nettype wire
